/* design/swbl_pkg.sv */
package swbl_pkg;

    // command codes
    localparam logic [1:0] OP_SET     = 2'd0;
    localparam logic [1:0] OP_SUSPEND = 2'd1;
    localparam logic [1:0] OP_RESUME  = 2'd2;

    // register indexes
    localparam int unsigned NUM_REGS  = 8;
    localparam int unsigned IDX_W     = $clog2(NUM_REGS);
    localparam logic [IDX_W-1:0] REG_START       = 3'd0;
    localparam logic [IDX_W-1:0] REG_ZERO_LOW    = 3'd1;
    localparam logic [IDX_W-1:0] REG_ZERO_HIGH   = 3'd2;
    localparam logic [IDX_W-1:0] REG_ONE_LOW     = 3'd3;
    localparam logic [IDX_W-1:0] REG_ONE_HIGH    = 3'd4;
    localparam logic [IDX_W-1:0] REG_END         = 3'd5;
    localparam logic [IDX_W-1:0] REG_ENABLE_HIGH = 3'd6;
    localparam logic [IDX_W-1:0] REG_ENABLE_LOW  = 3'd7;

    localparam int unsigned US_W     = 12;
    localparam int unsigned CFG_IDX_W = 4;

    typedef logic [US_W-1:0] us_t;

    // register reset values, in index order
    localparam us_t REG_RESET [NUM_REGS] = '{
        12'd10, 12'd20, 12'd5, 12'd5, 12'd20, 12'd10, 12'd200, 12'd800
    };

    // frame constants
    localparam logic [7:0] DEV_ADDR      = 8'h58;
    localparam us_t        SETTLE_US     = 12'd4000;
    localparam logic [6:0] MAX_LEVEL     = 7'd100;
    localparam logic [6:0] DEFAULT_LEVEL = 7'd30;
    localparam logic [4:0] MIN_CODE      = 5'd5;

    // segment positions: three enable segments, then the 37-segment frame
    localparam logic [5:0] POS_FRAME     = 6'd3;
    localparam logic [5:0] POS_LAST      = 6'd39;
    localparam logic [5:0] F_ADDR_FIRST  = 6'd1;
    localparam logic [5:0] F_ADDR_LAST   = 6'd16;
    localparam logic [5:0] F_EOS         = 6'd17;
    localparam logic [5:0] F_START2      = 6'd18;
    localparam logic [5:0] F_DATA_FIRST  = 6'd19;
    localparam logic [5:0] F_DATA_LAST   = 6'd34;
    localparam logic [5:0] F_END         = 6'd35;

    typedef struct packed {
        logic [1:0] op;
        logic [6:0] level;
    } cmd_t;

    typedef struct packed {
        logic       line_level;
        us_t        hold_us;
        logic       last;
    } seg_t;

    typedef enum logic [1:0] {
        KIND_FRAME,
        KIND_SUSPEND,
        KIND_RESUME
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [4:0] code;
    } job_t;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } back_state_t;

    // brightness level to 5-bit code through the range table
    function automatic logic [4:0] level_code(input logic [6:0] lvl);
        logic [6:0] l;
        logic [6:0] lm1;
        l   = (lvl > MAX_LEVEL) ? MAX_LEVEL : lvl;
        lm1 = l - 7'd1;
        if (l == 7'd0)
            level_code = MIN_CODE;
        else if (l <= 7'd84)
            level_code = MIN_CODE + lm1[6:2];
        else if (l <= 7'd87)
            level_code = 5'd26;
        else if (l <= 7'd90)
            level_code = 5'd27;
        else if (l <= 7'd93)
            level_code = 5'd28;
        else if (l <= 7'd96)
            level_code = 5'd29;
        else if (l <= 7'd99)
            level_code = 5'd30;
        else
            level_code = 5'd31;
    endfunction

endpackage

/* design/swbl_front.sv */
module swbl_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  swbl_pkg::cmd_t    cmd,
    input  logic              q_full,
    output logic              push,
    output swbl_pkg::job_t    push_job
);

    logic       powered_reg;
    logic       powered_next;
    logic [6:0] saved_level_reg;
    logic [6:0] saved_level_next;
    logic       accept;

    assign cmd_ready = !q_full;
    assign accept    = cmd_valid && cmd_ready;

    // classify the command and update power and level state
    always_comb
    begin
        powered_next     = powered_reg;
        saved_level_next = saved_level_reg;
        push             = 1'b0;
        push_job.kind    = swbl_pkg::KIND_FRAME;
        push_job.code    = swbl_pkg::level_code(saved_level_reg);
        if (accept)
        begin
            unique case (cmd.op)
                swbl_pkg::OP_SET:
                begin
                    saved_level_next = cmd.level;
                    push_job.code    = swbl_pkg::level_code(cmd.level);
                    push             = powered_reg;
                end
                swbl_pkg::OP_SUSPEND:
                begin
                    powered_next  = 1'b0;
                    push_job.kind = swbl_pkg::KIND_SUSPEND;
                    push          = 1'b1;
                end
                swbl_pkg::OP_RESUME:
                begin
                    powered_next  = 1'b1;
                    push_job.kind = swbl_pkg::KIND_RESUME;
                    push          = 1'b1;
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            powered_reg     <= 1'b1;
            saved_level_reg <= swbl_pkg::DEFAULT_LEVEL;
        end
        else
        begin
            powered_reg     <= powered_next;
            saved_level_reg <= saved_level_next;
        end
    end

endmodule

/* design/swbl_queue.sv */
module swbl_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  swbl_pkg::job_t    push_job,
    input  logic              pop,
    output logic              full,
    output logic              not_empty,
    output swbl_pkg::job_t    head
);

    swbl_pkg::job_t mem_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;
    logic           do_push;
    logic           do_pop;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (do_pop && !do_push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

endmodule

/* design/swbl_back.sv */
module swbl_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [swbl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  swbl_pkg::us_t                       cfg_data,
    input  logic                                q_not_empty,
    input  swbl_pkg::job_t                      q_head,
    output logic                                pop,
    output logic                                seg_valid,
    input  logic                                seg_ready,
    output swbl_pkg::seg_t                      seg
);

    swbl_pkg::us_t          regs_reg [swbl_pkg::NUM_REGS];
    swbl_pkg::back_state_t  state_reg;
    swbl_pkg::back_state_t  state_next;
    swbl_pkg::job_t         job_reg;
    logic [5:0]             pos_reg;
    logic [5:0]             pos_next;
    logic                   out_valid_reg;
    swbl_pkg::seg_t         out_reg;
    logic                   slot_free;
    logic                   load;
    swbl_pkg::seg_t         cur;
    logic [5:0]             f;
    logic [5:0]             t;
    logic [7:0]             word;
    logic                   bit_val;
    logic                   phase;
    logic [2:0]             bit_sel;

    assign slot_free = !out_valid_reg || seg_ready;
    assign load      = (state_reg == swbl_pkg::BK_RUN) && slot_free;
    assign seg_valid = out_valid_reg;
    assign seg       = out_reg;

    // timing registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < swbl_pkg::NUM_REGS; i++)
                regs_reg[i] <= swbl_pkg::REG_RESET[i];
        end
        else if (cfg_we && (cfg_index < swbl_pkg::CFG_IDX_W'(swbl_pkg::NUM_REGS)))
        begin
            regs_reg[cfg_index[swbl_pkg::IDX_W-1:0]] <= cfg_data;
        end
    end

    // segment at the current position
    always_comb
    begin
        f       = pos_reg - swbl_pkg::POS_FRAME;
        t       = 6'd0;
        word    = swbl_pkg::DEV_ADDR;
        cur     = '0;
        if (f >= swbl_pkg::F_DATA_FIRST)
        begin
            t    = f - swbl_pkg::F_DATA_FIRST;
            word = {3'b000, job_reg.code};
        end
        else
        begin
            t    = f - swbl_pkg::F_ADDR_FIRST;
        end
        phase   = t[0];
        bit_sel = 3'd7 - t[3:1];
        bit_val = word[bit_sel];

        if (job_reg.kind == swbl_pkg::KIND_SUSPEND)
        begin
            cur = '{line_level: 1'b0, hold_us: '0, last: 1'b1};
        end
        else
        begin
            case (pos_reg)
                6'd0: cur = '{1'b1, regs_reg[swbl_pkg::REG_ENABLE_HIGH], 1'b0};
                6'd1: cur = '{1'b0, regs_reg[swbl_pkg::REG_ENABLE_LOW], 1'b0};
                6'd2: cur = '{1'b1, swbl_pkg::SETTLE_US, 1'b0};
                default:
                begin
                    if (f == 6'd0 || f == swbl_pkg::F_START2)
                        cur = '{1'b1, regs_reg[swbl_pkg::REG_START], 1'b0};
                    else if (f == swbl_pkg::F_EOS || f == swbl_pkg::F_END)
                        cur = '{1'b0, regs_reg[swbl_pkg::REG_END], 1'b0};
                    else if (f > swbl_pkg::F_END)
                        cur = '{1'b1, '0, 1'b1};
                    else if (bit_val)
                        cur = '{phase, phase ? regs_reg[swbl_pkg::REG_ONE_HIGH]
                                             : regs_reg[swbl_pkg::REG_ONE_LOW], 1'b0};
                    else
                        cur = '{phase, phase ? regs_reg[swbl_pkg::REG_ZERO_HIGH]
                                             : regs_reg[swbl_pkg::REG_ZERO_LOW], 1'b0};
                end
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            swbl_pkg::BK_IDLE:
            begin
                if (q_not_empty)
                    state_next = swbl_pkg::BK_RUN;
            end
            swbl_pkg::BK_RUN:
            begin
                if (load && cur.last)
                    state_next = swbl_pkg::BK_IDLE;
            end
            default: state_next = swbl_pkg::BK_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        pop      = 1'b0;
        pos_next = pos_reg;
        unique case (state_reg)
            swbl_pkg::BK_IDLE:
            begin
                pop = q_not_empty;
                if (q_head.kind == swbl_pkg::KIND_FRAME)
                    pos_next = swbl_pkg::POS_FRAME;
                else
                    pos_next = 6'd0;
            end
            swbl_pkg::BK_RUN:
            begin
                if (load)
                    pos_next = pos_reg + 6'd1;
            end
            default: pop = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= swbl_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
            pos_reg       <= 6'd0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            if (load)
                out_valid_reg <= 1'b1;
            else if (seg_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (pop)
            job_reg <= q_head;
        if (load)
            out_reg <= cur;
    end

endmodule

/* design/single_wire_backlight_frame_sender_unit.sv */
// Single-wire backlight frame sender.
// cmd channel (valid/ready): op set level, suspend or resume, plus a level.
// seg channel (valid/ready): timed line segments, line level and hold in us,
// last marks the final segment of a command.
// cfg port: cfg_we writes cfg_data into timing register cfg_index at once;
// indexes of eight and above are ignored.
// A set while powered gives a 37-segment frame, a resume gives the enable
// sequence plus a frame (40 segments), a suspend gives one low segment.
// The first segment of a command goes out through the command queue, then the
// sequencer's job register, then the output register.
// Throughput: one segment per cycle while the receiver takes them; between
// commands the sequencer passes through its idle state to pick the next one
// up from the two-entry command queue.
// cmd_ready only drops when the queue is full, so commands are taken while
// segments of earlier ones are still going out.
// Reset empties the queue and output register, restores the timing registers
// to their defaults, sets powered and the saved level 30.
// When the receiver stalls the output register holds its segment and the
// sequencer waits; the queue keeps taking commands until it fills.
module single_wire_backlight_frame_sender_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cmd_valid,
    output logic                                cmd_ready,
    input  swbl_pkg::cmd_t                      cmd,
    output logic                                seg_valid,
    input  logic                                seg_ready,
    output swbl_pkg::seg_t                      seg,
    input  logic                                cfg_we,
    input  logic [swbl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  swbl_pkg::us_t                       cfg_data
);

    logic           push;
    swbl_pkg::job_t push_job;
    logic           pop;
    logic           q_full;
    logic           q_not_empty;
    swbl_pkg::job_t q_head;

    // command decode and state
    swbl_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd      (cmd),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    // command queue
    swbl_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .full     (q_full),
        .not_empty(q_not_empty),
        .head     (q_head)
    );

    // segment sequencer
    swbl_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_not_empty(q_not_empty),
        .q_head     (q_head),
        .pop        (pop),
        .seg_valid  (seg_valid),
        .seg_ready  (seg_ready),
        .seg        (seg)
    );

endmodule

/* design/swbl_checker.sv */
module swbl_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  logic              cmd_ready,
    input  logic              seg_valid,
    input  logic              seg_ready,
    input  swbl_pkg::seg_t    seg
);

    // a stalled segment holds
    assert property (@(posedge clk) disable iff (!rst_n)
        seg_valid && !seg_ready |=> seg_valid && $stable(seg))
        else $error("segment changed while stalled");

    // queue only fills by taking an item
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(cmd_ready) |-> $past(cmd_valid && cmd_ready))
        else $error("cmd_ready dropped without an item");

    // no segment right out of reset
    assert property (@(posedge clk)
        rst_n && !$past(rst_n) |-> !seg_valid)
        else $error("segment valid right after reset");

    // queue is not full right out of reset
    assert property (@(posedge clk)
        rst_n && !$past(rst_n) |-> cmd_ready)
        else $error("cmd_ready low right after reset");

endmodule

bind single_wire_backlight_frame_sender_unit swbl_checker u_swbl_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .seg_valid(seg_valid),
    .seg_ready(seg_ready),
    .seg      (seg)
);
